// File: hw/rtl/spq_pkg.sv
// Shared types and codes for the stable priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // One stored entry: weight is the sort key, value rides along.
    typedef struct packed {
        logic signed [31:0] weight;
        logic signed [31:0] value;
    } t_entry;

    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_PLACE = 5'b00100,
        S_DEQ   = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    localparam int unsigned OCC_W = 6;

endpackage

// File: hw/rtl/spq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module spq_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/stable_priority_queue.sv
// Top level of the stable priority queue: control, pointers and entry store.
`timescale 1ns / 1ps

// Stable sorted priority queue holding up to CAPACITY entries of value and weight.
// Input channel (i_in_valid / o_in_stall): one transaction is one command;
// enqueue inserts {value, weight} after every entry of equal or smaller weight,
// dequeue removes the front entry (smallest weight, oldest among equals).
// Output channel (o_out_valid / i_out_stall): exactly one result transaction per
// command, carrying the dequeued value and weight (zero otherwise), a status
// (done, dequeue on empty, enqueue refused because full) and the occupancy after
// the command.
// Entries sit in a circular buffer in one RAM with a registered read. Dequeue
// advances the head pointer and reads the front entry. Enqueue walks backwards
// from the tail, one stored entry per cycle, moving each heavier entry up a slot
// until its place is found. An enqueue into an empty queue and refused or
// empty-queue commands go straight to the result.
// One command is in work at a time; the input is stalled until its result has
// been placed in the output register, so a new command may be taken while that
// result still waits. A stalled output holds its result unchanged.
// Reset empties the queue at once (pointers and count cleared); stored entries
// need no clearing as only occupied slots are ever read.

module stable_priority_queue #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_command,
    input  logic signed [31:0] i_item_value,
    input  logic signed [31:0] i_item_weight,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_out_value,
    output logic signed [31:0] o_out_weight,
    output logic [1:0]         o_status,
    output logic [5:0]         o_occupancy
);

    import spq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Circular index arithmetic on a buffer of CAPACITY slots.
    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] x);
        return (x == AW'(CAPACITY - 1)) ? '0 : x + AW'(1);
    endfunction

    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] x);
        return (x == '0) ? AW'(CAPACITY - 1) : x - AW'(1);
    endfunction

    // Control state
    t_state        r_state, n_state;
    logic [AW-1:0] r_head, n_head;   // slot of the front entry
    logic [AW-1:0] r_tail, n_tail;   // first free slot
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_hole, n_hole;   // free slot during the insertion walk
    logic          r_out_valid;

    // Payload held through a command
    t_entry        r_new, n_new;
    t_entry        r_res, n_res;
    t_status       r_res_status, n_res_status;

    // Output register
    logic signed [31:0] r_out_value;
    logic signed [31:0] r_out_weight;
    t_status            r_out_status;
    logic [OCC_W-1:0]   r_out_occ;

    // RAM port signals
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic [AW-1:0] ram_raddr;
    t_entry        ram_rdata;

    logic          in_accept;
    logic          out_free;
    logic          load_out;
    logic [AW-1:0] walk_slot;
    t_entry        in_entry;

    spq_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == S_RESP) && out_free;
    // slot whose entry is on the read port while walking
    assign walk_slot  = idx_prev(r_hole);
    assign in_entry   = '{weight: i_item_weight, value: i_item_value};

    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_hole       = r_hole;
        n_new        = r_new;
        n_res        = r_res;
        n_res_status = r_res_status;
        ram_we       = 1'b0;
        ram_waddr    = r_hole;
        ram_wdata    = r_new;
        ram_raddr    = walk_slot;

        unique case (r_state)
            S_IDLE: begin
                n_new        = in_entry;
                n_res        = '0;
                n_res_status = ST_DONE;
                if (i_command == CMD_DEQUEUE) begin
                    ram_raddr = r_head;
                end else begin
                    ram_raddr = idx_prev(r_tail);
                end
                if (in_accept) begin
                    if (i_command == CMD_DEQUEUE) begin
                        if (r_count == '0) begin
                            n_res_status = ST_EMPTY;
                            n_state      = S_RESP;
                        end else begin
                            // front entry arrives on the read port next cycle
                            n_head  = idx_next(r_head);
                            n_count = r_count - CW'(1);
                            n_state = S_DEQ;
                        end
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_res_status = ST_FULL;
                        n_state      = S_RESP;
                    end else begin
                        n_tail  = idx_next(r_tail);
                        n_count = r_count + CW'(1);
                        if (r_count == '0) begin
                            // empty queue: store straight into the free slot
                            ram_we    = 1'b1;
                            ram_waddr = r_tail;
                            ram_wdata = in_entry;
                            n_state   = S_RESP;
                        end else begin
                            n_hole  = r_tail;
                            n_state = S_WALK;
                        end
                    end
                end
            end
            S_WALK: begin
                ram_we    = 1'b1;
                ram_waddr = r_hole;
                if (ram_rdata.weight > r_new.weight) begin
                    // move the heavier entry up and follow it down
                    ram_wdata = ram_rdata;
                    n_hole    = walk_slot;
                    ram_raddr = idx_prev(walk_slot);
                    if (walk_slot == r_head) begin
                        n_state = S_PLACE;
                    end
                end else begin
                    ram_wdata = r_new;
                    n_state   = S_RESP;
                end
            end
            S_PLACE: begin
                ram_we    = 1'b1;
                ram_wdata = r_new;
                n_state   = S_RESP;
            end
            S_DEQ: begin
                n_res   = ram_rdata;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_hole      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
            r_hole  <= n_hole;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the command payload and the result; no reset needed.
    always_ff @(posedge i_clk) begin
        r_new        <= n_new;
        r_res        <= n_res;
        r_res_status <= n_res_status;
        if (load_out) begin
            r_out_value  <= r_res.value;
            r_out_weight <= r_res.weight;
            r_out_status <= r_res_status;
            r_out_occ    <= OCC_W'(r_count);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_value  = r_out_value;
    assign o_out_weight = r_out_weight;
    assign o_status     = r_out_status;
    assign o_occupancy  = r_out_occ;

endmodule
